/* rtl/modbus_rtu_slave_holding_regs_assert.svh */
// Assertion macros for the Modbus RTU slave block.
// Included by the modules that carry concurrent checks.
`ifndef MODBUS_RTU_SLAVE_HOLDING_REGS_ASSERT_SVH
`define MODBUS_RTU_SLAVE_HOLDING_REGS_ASSERT_SVH
`ifndef SYNTHESIS
`define MB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define MB_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define MB_ASSERT(label, clk, rst, prop)
`define MB_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/mbrtu_pkg.sv */
// Package for the Modbus RTU slave: constants, types, CRC function.
// No dependencies.
`timescale 1ns / 1ps
package mbrtu_pkg;
   localparam int NUM_HOLD_REGS_DEF = 16;
   localparam logic [7:0] SLAVE_ID_RST = 8'd1;
   localparam logic [7:0] FUNC_READ = 8'd3;
   localparam logic [7:0] FUNC_WRITE = 8'd6;
   localparam logic [7:0] EXC_FLAG = 8'h80;
   localparam logic [7:0] EXC_FUNC = 8'd1;
   localparam logic [7:0] EXC_ADDR = 8'd2;
   localparam logic [7:0] EXC_VALUE = 8'd3;
   localparam logic [7:0] EXC_CRC = 8'd4;
   localparam logic [7:0] CNT_MAX = 8'hFF;

   typedef enum logic [2:0] {
      ST_RX, ST_JUDGE, ST_HEAD, ST_BODY, ST_CRC_LO, ST_CRC_HI
   } state_type;

   // byte source selector for the datapath
   typedef enum logic [2:0] {
      SEL_ID, SEL_FUNC, SEL_THIRD, SEL_REG_HI, SEL_REG_LO, SEL_WORD_HI, SEL_WORD_LO,
      SEL_CRC
   } sel_type;

   typedef struct packed {
      logic     clr_tx;
      logic     emit;
      sel_type  sel;
      logic     crc_hi;
      logic     last;
      logic     reg_step;
      logic     reg_write;
   } cmd_type;

   typedef struct packed {
      logic       frame_end;
      logic       answer;
      logic       is_exc;
      logic       is_write;
      logic       body_done;
   } sts_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
      end
      return x;
   endfunction
endpackage

/* rtl/mbrtu_stream_if.sv */
// Valid/ready byte stream interface with last marker.
// No dependencies.
`timescale 1ns / 1ps
interface mbrtu_stream_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;
   logic       last;
   modport source (output valid, output data, output last, input ready);
   modport sink (input valid, input data, input last, output ready);
endinterface

/* rtl/mbrtu_datapath.sv */
// Datapath: frame capture, CRC, register file, response byte register.
// Depends on mbrtu_pkg and the assertion header.
`timescale 1ns / 1ps
`include "modbus_rtu_slave_holding_regs_assert.svh"
module mbrtu_datapath #(
   parameter int NUM_HOLD_REGS = mbrtu_pkg::NUM_HOLD_REGS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rx_take,
   input  logic [7:0]         rx_byte,
   input  logic               rx_last,
   input  logic [7:0]         slave_id,
   input  mbrtu_pkg::cmd_type cmd,
   output mbrtu_pkg::sts_type sts,
   output logic [7:0]         tx_byte,
   output logic               tx_last
);
   import mbrtu_pkg::*;
   localparam int AW = (NUM_HOLD_REGS > 1) ? $clog2(NUM_HOLD_REGS) : 1;

   logic [15:0] regs_ff [NUM_HOLD_REGS];
   logic [7:0]  count_ff, count_in;
   logic [7:0]  hdr_ff [6];
   logic [7:0]  tail0_ff, tail1_ff;
   logic [15:0] rx_crc_ff, rx_crc_in, tx_crc_ff;
   logic [7:0]  exc_ff, func_ff;
   logic        ans_ff, exc_flag_ff, wr_ff;
   logic [AW-1:0] idx_ff;
   logic [4:0]  left_ff;
   logic [15:0] rd_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [15:0] start, word;
   logic [16:0] endp;
   logic [7:0]  hb, ev;
   logic        f0;

   assign start = {hdr_ff[2], hdr_ff[3]};
   assign word = {hdr_ff[4], hdr_ff[5]};
   assign endp = {1'b0, start} + {1'b0, word};
   assign f0 = (count_ff == 8'd0);
   assign count_in = (count_ff == CNT_MAX) ? count_ff : count_ff + 8'd1;
   assign rx_crc_in = f0 ? 16'hFFFF :
                      ((count_ff >= 8'd2) ? crc_feed(rx_crc_ff, tail0_ff) : rx_crc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < 6; i++) hdr_ff[i] <= '0;
         tail0_ff <= '0;
         tail1_ff <= '0;
         rx_crc_ff <= 16'hFFFF;
         ans_ff <= 1'b0;
      end else if (rx_take) begin
         for (int i = 0; i < 6; i++) begin
            if (count_ff == 8'(i)) hdr_ff[i] <= rx_byte;
            else if (f0) hdr_ff[i] <= '0;
         end
         tail0_ff <= f0 ? 8'd0 : tail1_ff;
         tail1_ff <= rx_byte;
         rx_crc_ff <= rx_crc_in;
         if (rx_last) begin
            count_ff <= '0;
            ans_ff <= (count_in >= 8'd4) && ((f0 ? rx_byte : hdr_ff[0]) == slave_id);
         end else begin
            count_ff <= count_in;
            ans_ff <= 1'b0;
         end
      end
   end

   // judge frame in the cycle after the last byte is taken
   logic [7:0] ex;
   always_comb begin
      ex = '0;
      if (rx_crc_ff != {tail1_ff, tail0_ff}) ex = EXC_CRC;
      if (start >= 16'(NUM_HOLD_REGS)) ex = EXC_ADDR;
      if (ex == '0) begin
         if (hdr_ff[1] == FUNC_READ) begin
            if (word == 16'd0 || endp > 17'(NUM_HOLD_REGS)) ex = EXC_VALUE;
         end else if (hdr_ff[1] != FUNC_WRITE) ex = EXC_FUNC;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_tx) begin
         exc_ff <= ex;
         func_ff <= hdr_ff[1];
         exc_flag_ff <= (ex != '0);
         wr_ff <= (ex == '0) && (hdr_ff[1] == FUNC_WRITE);
         idx_ff <= start[AW-1:0];
         left_ff <= word[4:0];
      end else if (cmd.reg_step) begin
         idx_ff <= idx_ff + AW'(1);
         left_ff <= left_ff - 5'd1;
      end
   end

   // register file: one write, one registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_HOLD_REGS; i++) regs_ff[i] <= '0;
      end else if (cmd.reg_write) begin
         regs_ff[idx_ff] <= word;
      end
      rd_ff <= regs_ff[idx_ff];
   end

   assign ev = exc_flag_ff ? exc_ff : (wr_ff ? start[15:8] : {word[6:0], 1'b0});
   always_comb begin
      case (cmd.sel)
         SEL_ID:      hb = slave_id;
         SEL_FUNC:    hb = exc_flag_ff ? (func_ff | EXC_FLAG) : func_ff;
         SEL_THIRD:   hb = ev;
         SEL_REG_HI:  hb = wr_ff ? start[7:0] : rd_ff[15:8];
         SEL_REG_LO:  hb = rd_ff[7:0];
         SEL_WORD_HI: hb = word[15:8];
         SEL_WORD_LO: hb = word[7:0];
         SEL_CRC:     hb = cmd.crc_hi ? tx_crc_ff[15:8] : tx_crc_ff[7:0];
         default:     hb = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) tx_crc_ff <= 16'hFFFF;
      else if (cmd.clr_tx) tx_crc_ff <= 16'hFFFF;
      else if (cmd.emit && cmd.sel != SEL_CRC) tx_crc_ff <= crc_feed(tx_crc_ff, hb);
      if (cmd.emit) begin
         byte_ff <= hb;
         last_ff <= cmd.last;
      end
   end

   assign tx_byte = byte_ff;
   assign tx_last = last_ff;
   assign sts.frame_end = rx_take && rx_last;
   assign sts.answer = ans_ff;
   assign sts.is_exc = exc_flag_ff;
   assign sts.is_write = wr_ff;
   assign sts.body_done = (left_ff == 5'd1);

   `MB_ASSERT(a_cnt_clr, clock, reset, (rx_take && rx_last) |=> (count_ff == 8'd0))
   `MB_ASSERT(a_crc_init, clock, reset, cmd.clr_tx |=> (tx_crc_ff == 16'hFFFF))
   `MB_ASSERT(a_wr_ok, clock, reset, cmd.reg_write |-> (wr_ff && !exc_flag_ff))
endmodule

/* rtl/mbrtu_ctrl.sv */
// Controller: sequences the response bytes and the output handshake.
// Depends on mbrtu_pkg and the assertion header.
`timescale 1ns / 1ps
`include "modbus_rtu_slave_holding_regs_assert.svh"
module mbrtu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  mbrtu_pkg::sts_type sts,
   input  logic               out_ready,
   output logic               out_valid,
   output logic               in_ready,
   output mbrtu_pkg::cmd_type cmd
);
   import mbrtu_pkg::*;
   state_type state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic vld_ff, vld_in;
   logic judge_ff;
   logic rd_wait_ff, rd_wait_in;
   logic free;

   assign free = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign in_ready = (state_ff == ST_RX) && !judge_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RX;
         step_ff <= '0;
         vld_ff <= 1'b0;
         judge_ff <= 1'b0;
         rd_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         vld_ff <= vld_in;
         judge_ff <= sts.frame_end;
         rd_wait_ff <= rd_wait_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      vld_in = vld_ff && !out_ready;
      rd_wait_in = 1'b0;
      cmd = '0;
      cmd.sel = SEL_ID;
      case (state_ff)
         ST_RX: begin
            if (judge_ff && sts.answer) begin
               cmd.clr_tx = 1'b1;
               state_in = ST_HEAD;
               step_in = '0;
            end
         end
         ST_HEAD: begin
            if (free) begin
               cmd.emit = 1'b1;
               vld_in = 1'b1;
               step_in = step_ff + 3'd1;
               case (step_ff)
                  3'd0: cmd.sel = SEL_ID;
                  3'd1: cmd.sel = SEL_FUNC;
                  default: begin
                     cmd.sel = SEL_THIRD;
                     step_in = '0;
                     if (sts.is_exc) state_in = ST_CRC_LO;
                     else begin
                        state_in = ST_BODY;
                        rd_wait_in = !sts.is_write;
                     end
                  end
               endcase
            end
         end
         ST_BODY: begin
            if (sts.is_write) begin
               if (free) begin
                  cmd.emit = 1'b1;
                  vld_in = 1'b1;
                  step_in = step_ff + 3'd1;
                  case (step_ff)
                     3'd0: begin
                        cmd.sel = SEL_REG_HI;
                        cmd.reg_write = 1'b1;
                     end
                     3'd1: cmd.sel = SEL_WORD_HI;
                     default: begin
                        cmd.sel = SEL_WORD_LO;
                        state_in = ST_CRC_LO;
                     end
                  endcase
               end
            end else if (!rd_wait_ff && free) begin
               cmd.emit = 1'b1;
               vld_in = 1'b1;
               if (step_ff == 3'd0) begin
                  cmd.sel = SEL_REG_HI;
                  step_in = 3'd1;
               end else begin
                  cmd.sel = SEL_REG_LO;
                  step_in = '0;
                  cmd.reg_step = !sts.body_done;
                  rd_wait_in = 1'b1;
                  if (sts.body_done) state_in = ST_CRC_LO;
               end
            end
         end
         ST_CRC_LO: begin
            if (free) begin
               cmd.emit = 1'b1;
               cmd.sel = SEL_CRC;
               vld_in = 1'b1;
               state_in = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (free) begin
               cmd.emit = 1'b1;
               cmd.sel = SEL_CRC;
               cmd.crc_hi = 1'b1;
               cmd.last = 1'b1;
               vld_in = 1'b1;
               state_in = ST_RX;
            end
         end
         default: state_in = ST_RX;
      endcase
   end

   `MB_ASSERT(a_no_rx_busy, clock, reset, (state_ff != ST_RX) |-> !in_ready)
   `MB_ASSERT(a_hold, clock, reset, (out_valid && !out_ready) |=> out_valid)
   `MB_ASSERT(a_emit_free, clock, reset, cmd.emit |-> free)
endmodule

/* rtl/modbus_rtu_slave_holding_regs.sv */
// Top level of the Modbus RTU slave (functions 3 and 6).
// Depends on mbrtu_pkg, mbrtu_stream_if, mbrtu_ctrl, mbrtu_datapath.
//
//   channel | dir | payload
//   req     | in  | rx_byte (data), rx_last (last)
//   rsp     | out | tx_byte (data), tx_last (last)
//   csr     | in  | slave_id write
//
// Non-final bytes: one per cycle. Final byte: the frame is judged, then, if it is
// answered, 5 to 37 response bytes, one per cycle unless rsp stalls; a read
// pauses before each register for the register-file read port. req is held off
// until the response has been issued. Synchronous reset clears the register file at once.
`timescale 1ns / 1ps
module modbus_rtu_slave_holding_regs #(
   parameter int NUM_HOLD_REGS = mbrtu_pkg::NUM_HOLD_REGS_DEF
) (
   input logic        clock,
   input logic        reset,
   mbrtu_stream_if.sink   req,
   mbrtu_stream_if.source rsp,
   input logic        csr_write,
   input logic [7:0]  csr_wdata
);
   import mbrtu_pkg::*;
   logic [7:0] slave_id_ff;
   cmd_type cmd;
   sts_type sts;
   logic rx_take;

   always_ff @(posedge clock) begin
      if (reset) slave_id_ff <= SLAVE_ID_RST;
      else if (csr_write) slave_id_ff <= csr_wdata;
   end

   assign rx_take = req.valid && req.ready;

   mbrtu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .sts(sts), .out_ready(rsp.ready),
      .out_valid(rsp.valid), .in_ready(req.ready), .cmd(cmd)
   );

   mbrtu_datapath #(.NUM_HOLD_REGS(NUM_HOLD_REGS)) u_dp (
      .clock(clock), .reset(reset), .rx_take(rx_take), .rx_byte(req.data),
      .rx_last(req.last), .slave_id(slave_id_ff), .cmd(cmd), .sts(sts),
      .tx_byte(rsp.data), .tx_last(rsp.last)
   );
endmodule

/* tb/modbus_rtu_slave_holding_regs_tb.sv */
// Self-checking testbench for the Modbus RTU slave holding-register block.
// Depends on mbrtu_pkg, mbrtu_stream_if and the block's top level.
`timescale 1ns / 1ps
module modbus_rtu_slave_holding_regs_tb;
   import mbrtu_pkg::*;

   localparam int NREGS = NUM_HOLD_REGS_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [7:0] csr_wdata = 8'h00;
   logic req_accept = 1'b0;

   mbrtu_stream_if req_if ();
   mbrtu_stream_if rsp_if ();

   modbus_rtu_slave_holding_regs DUT (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [7:0]  my_id;
   logic [15:0] regs [NREGS];
   logic [7:0]  fcount;
   logic [7:0]  head [6];
   logic [7:0]  tail [2];
   logic [15:0] rcrc;
   logic [15:0] tcrc;

   byte_type tx_pending [$];
   byte_type rsp_expected [$];

   int errors = 0;
   int idle_cnt = 0;
   int send_idle_pct = 9;
   int recv_idle_pct = 58;
   int hold_off = 0;
   bit done_sending = 0;

   function automatic logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      logic [15:0] x;
      x = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) x = x[0] ? ((x >> 1) ^ 16'hA001) : (x >> 1);
      return x;
   endfunction

   task automatic emit(logic [7:0] b, logic l);
      byte_type e;
      e.data = b;
      e.last = l;
      rsp_expected.push_back(e);
      tcrc = crc_byte(tcrc, b);
   endtask

   task automatic emit_crc();
      logic [15:0] c;
      c = tcrc;
      emit(c[7:0], 1'b0);
      emit(c[15:8], 1'b1);
   endtask

   task automatic predict_frame_byte(logic [7:0] b, logic l);
      logic [7:0] cnt, fn, code;
      logic [15:0] start, word, rcv;
      code = 8'h00;
      if (fcount == 0) begin
         foreach (head[i]) head[i] = 8'h00;
         tail[0] = 8'h00;
         tail[1] = 8'h00;
         rcrc = 16'hFFFF;
      end
      if (fcount < 6) head[fcount] = b;
      if (fcount >= 2) rcrc = crc_byte(rcrc, tail[0]);
      tail[0] = tail[1];
      tail[1] = b;
      if (fcount != CNT_MAX) fcount++;
      if (!l) return;
      cnt = fcount;
      fcount = 0;
      if (cnt < 4 || head[0] != my_id) return;
      tcrc = 16'hFFFF;
      fn = head[1];
      start = {head[2], head[3]};
      word = {head[4], head[5]};
      rcv = {tail[1], tail[0]};
      if (rcrc != rcv) code = EXC_CRC;
      if (start >= NREGS) code = EXC_ADDR;
      if (code == 0) begin
         if (fn == FUNC_READ) begin
            if (word == 0 || 32'(start) + 32'(word) > NREGS) begin
               code = EXC_VALUE;
            end else begin
               emit(my_id, 1'b0);
               emit(FUNC_READ, 1'b0);
               emit(8'(word * 2), 1'b0);
               for (int i = 0; i < word; i++) begin
                  emit(regs[start + i][15:8], 1'b0);
                  emit(regs[start + i][7:0], 1'b0);
               end
               emit_crc();
               return;
            end
         end else if (fn == FUNC_WRITE) begin
            regs[start] = word;
            emit(my_id, 1'b0);
            emit(FUNC_WRITE, 1'b0);
            emit(start[15:8], 1'b0);
            emit(start[7:0], 1'b0);
            emit(word[15:8], 1'b0);
            emit(word[7:0], 1'b0);
            emit_crc();
            return;
         end else begin
            code = EXC_FUNC;
         end
      end
      emit(my_id, 1'b0);
      emit(fn | EXC_FLAG, 1'b0);
      emit(code, 1'b0);
      emit_crc();
   endtask

   // queue a frame; good_crc appends a correct CRC, otherwise a random one
   task automatic queue_frame(logic [7:0] body [$], bit good_crc);
      logic [15:0] c;
      byte_type e;
      c = 16'hFFFF;
      foreach (body[i]) c = crc_byte(c, body[i]);
      if (!good_crc) c = 16'($urandom);
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
      foreach (body[i]) begin
         e.data = body[i];
         e.last = (i == body.size() - 1);
         tx_pending.push_back(e);
      end
   endtask

   task automatic queue_request(logic [7:0] id, logic [7:0] fn, logic [15:0] a,
                                logic [15:0] w, bit good_crc);
      logic [7:0] body [$];
      body = '{id, fn, a[15:8], a[7:0], w[15:8], w[7:0]};
      queue_frame(body, good_crc);
   endtask

   task automatic queue_raw(logic [7:0] bytes [$]);
      byte_type e;
      foreach (bytes[i]) begin
         e.data = bytes[i];
         e.last = (i == bytes.size() - 1);
         tx_pending.push_back(e);
      end
   endtask

   task automatic wait_drained();
      while (tx_pending.size() != 0 || rsp_expected.size() != 0 || req_if.valid)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_slave_id(logic [7:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      my_id = v;
   endtask

   task automatic queue_random_frame();
      int kind;
      logic [15:0] a, w;
      logic [7:0] body [$];
      kind = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, NREGS - 1));
      w = 16'($urandom);
      if (kind < 40) begin
         w = 16'($urandom_range(1, NREGS - a[3:0]));
         if ($urandom_range(0, 7) == 0) w = 16'($urandom_range(0, 20));
         queue_request(my_id, FUNC_READ, a, w, $urandom_range(0, 9) != 0);
      end else if (kind < 80) begin
         queue_request(my_id, FUNC_WRITE, a, w, $urandom_range(0, 9) != 0);
      end else if (kind < 87) begin
         queue_request(my_id, 8'($urandom), a, w, 1'b1);
      end else if (kind < 92) begin
         queue_request(8'($urandom), FUNC_READ, a, 16'd1, 1'b1);
      end else begin
         // short or odd-length noise
         repeat ($urandom_range(1, 9)) body.push_back(8'($urandom));
         if ($urandom_range(0, 1)) body[0] = my_id;
         queue_raw(body);
      end
   endtask

   initial begin
      logic [7:0] body [$];
      req_if.valid = 1'b0;
      req_if.data = 8'h00;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      my_id = SLAVE_ID_RST;
      foreach (regs[i]) regs[i] = 16'h0000;
      fcount = 0;
      foreach (head[i]) head[i] = 8'h00;
      tail[0] = 8'h00;
      tail[1] = 8'h00;
      rcrc = 16'hFFFF;
      tcrc = 16'hFFFF;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads of the cleared file, writes at the extremes, every error
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'd0, 16'(NREGS), 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_WRITE, 16'd0, 16'hFFFF, 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_WRITE, 16'(NREGS - 1), 16'hA55A, 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'(NREGS - 1), 16'd1, 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'd0, 16'd0, 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'd4, 16'(NREGS), 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'hFFFF, 16'd1, 1'b1);
      queue_request(SLAVE_ID_RST, FUNC_WRITE, 16'(NREGS), 16'd1, 1'b0);
      queue_request(SLAVE_ID_RST, FUNC_WRITE, 16'd2, 16'd7, 1'b0);
      queue_request(SLAVE_ID_RST, 8'hFF, 16'd0, 16'd0, 1'b1);
      queue_request(8'h02, FUNC_READ, 16'd0, 16'd1, 1'b1);
      queue_raw('{SLAVE_ID_RST, FUNC_READ, 8'h00});
      queue_raw('{SLAVE_ID_RST, FUNC_WRITE, 8'h00, 8'h03});
      queue_raw('{SLAVE_ID_RST, FUNC_READ, 8'h00, 8'h00, 8'h7F});
      // long frame runs the byte count into saturation
      body = {};
      repeat (258) body.push_back(8'($urandom));
      body[0] = SLAVE_ID_RST;
      queue_raw(body);
      queue_request(SLAVE_ID_RST, FUNC_READ, 16'd0, 16'(NREGS), 1'b1);
      wait_drained();

      // long receiver hold-off while frames keep coming
      hold_off = 400;
      repeat (3) queue_request(my_id, FUNC_READ, 16'd0, 16'(NREGS), 1'b1);
      wait_drained();

      foreach (body[i]) body[i] = 8'h00;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_slave_id(8'h00);
            1: set_slave_id(8'hFF);
            2: begin set_slave_id(8'h5A); send_idle_pct = 58; recv_idle_pct = 9; end
            3: set_slave_id(8'hA5);
            4: begin set_slave_id(8'h01); send_idle_pct = 0; recv_idle_pct = 0; end
            default: set_slave_id(8'($urandom));
         endcase
         while (tx_pending.size() < 6) queue_random_frame();
         wait_drained();
      end
      done_sending = 1;
   end

   // driver: offers pending bytes with random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (req_if.valid && !req_accept) begin
            // hold current byte
         end else if (tx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.data <= tx_pending[0].data;
            req_if.last <= tx_pending[0].last;
            void'(tx_pending.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: random ready, plus a counted hold-off stretch
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_if.ready <= 1'b0;
            hold_off <= hold_off - 1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      byte_type got, want;
      req_accept <= 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            req_accept <= 1'b1;
            predict_frame_byte(req_if.data, req_if.last);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.data = rsp_if.data;
            got.last = rsp_if.last;
            if (rsp_expected.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response byte %h last %b",
                                           got.data, got.last);
            end else begin
               want = rsp_expected.pop_front();
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected byte %h last %b, got byte %h last %b",
                              want.data, want.last, got.data, got.last);
               end
            end
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
             (tx_pending.size() == 0 && rsp_expected.size() == 0 && !req_if.valid))
            idle_cnt <= 0;
         else
            idle_cnt <= idle_cnt + 1;
      end
   end

   initial begin
      wait (done_sending);
      if (errors == 0 && rsp_expected.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      wait (idle_cnt >= STALL_LIMIT);
      $display("Some tests failed");
      $finish;
   end
endmodule
